// File: sv/ukst_pkg.sv
// Package for the unique key set table.
// Holds field widths, request action codes and result status codes.
// No dependencies.
`default_nettype none

package ukst_pkg;

   localparam int ACTION_W = 2;
   localparam int KEY_W    = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   // Request action codes; code three is unused and ignored.
   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE      = 2'd0,
      ST_PRESENT   = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

endpackage

`default_nettype wire

// File: sv/ukst_ifs.sv
// Channel interfaces for the unique key set table: request and response.
// Depends on ukst_pkg for field widths.
`default_nettype none

interface ukst_req_if;
   logic                         valid;
   logic                         ready;
   logic [ukst_pkg::ACTION_W-1:0] action;
   logic [ukst_pkg::KEY_W-1:0]    key;

   modport source (output valid, output action, output key, input ready);
   modport sink   (input valid, input action, input key, output ready);
endinterface

interface ukst_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ukst_pkg::STATUS_W-1:0] status;
   logic [ukst_pkg::COUNT_W-1:0]  entry_count;

   modport source (output valid, output status, output entry_count, input ready);
   modport sink   (input valid, input status, input entry_count, output ready);
endinterface

`default_nettype wire

// File: sv/unique_key_set_table.sv
// Top level of the unique key set table: a bounded set of distinct keys.
// Depends on ukst_pkg, ukst_req_if, ukst_rsp_if and ukst_ram.
`default_nettype none

// Usage
//   req_ch carries one transaction per request: action (insert, lookup,
//   delete) and key. rsp_ch returns exactly one transaction per request:
//   status (done, already present, not found, table full) and entry_count,
//   the number of keys stored after the request.
// Walk and request flow
//   A request walks the key RAM one slot per cycle through its single read
//   port and one equality comparator. Every action stops at the first
//   hit; an insert of an absent key walks all CAPACITY slots to find the
//   lowest free one. The unused action code skips the walk and goes
//   straight to the finish step. req_ch.ready is high only while the
//   sequencer is idle, so one request is in flight at a time; the next
//   can be taken as soon as the response is valid.
// Reset
//   Synchronous, active high. Clears all valid marks, the entry count and
//   any pending response; key RAM contents are left as they are and are
//   never compared until written.
// Stall
//   The response sits in an output register. A new request can be taken
//   while it waits; the block holds in its finish step, without changing
//   the table, until the old response leaves.

module unique_key_set_table #(
   parameter int CAPACITY  = 64,
   parameter int KEY_WIDTH = 32
) (
   input wire logic   clock,
   input wire logic   reset,
   ukst_req_if.sink   req_ch,
   ukst_rsp_if.source rsp_ch
);

   import ukst_pkg::*;

   localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int KEXT = (KEY_WIDTH > KEY_W) ? KEY_WIDTH : KEY_W;
   localparam int CWX  = (CW > COUNT_W) ? CW : COUNT_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } fsm_type;

   // Sequencer and response registers.
   fsm_type                state_ff, state_in;
   logic                   rsp_vld_ff, rsp_vld_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]     rsp_count_ff, rsp_count_in;

   // Table control state.
   logic                   slot_vld_ff [CAPACITY];
   logic                   slot_vld_in [CAPACITY];
   logic [CW-1:0]          cnt_ff, cnt_in;

   // Request held during the walk.
   logic [ACTION_W-1:0]    action_ff, action_in;
   logic [KEY_WIDTH-1:0]   key_ff, key_in;

   // Walk: issue side (RAM address) and check side (RAM data back).
   logic [IW-1:0]          issue_idx_ff, issue_idx_in;
   logic                   issue_done_ff, issue_done_in;
   logic                   chk_pend_ff, chk_pend_in;
   logic [IW-1:0]          chk_idx_ff, chk_idx_in;
   logic                   chk_vld_ff, chk_vld_in;
   logic                   hit_ff, hit_in;
   logic [IW-1:0]          hit_idx_ff, hit_idx_in;
   logic                   free_found_ff, free_found_in;
   logic [IW-1:0]          free_idx_ff, free_idx_in;

   logic [KEY_WIDTH-1:0]   rd_data;
   logic                   ram_wr_en;
   logic                   ram_rd_en;
   logic [KEXT-1:0]        key_ext;
   logic [CWX-1:0]         cnt_ext;
   logic                   req_take;
   logic                   rsp_take;
   logic                   fin_go;
   logic                   match;

   assign req_take = req_ch.valid && req_ch.ready;
   assign rsp_take = rsp_vld_ff && rsp_ch.ready;
   // Finish only once the output register is free or being emptied.
   assign fin_go   = (state_ff == S_FINISH) && (!rsp_vld_ff || rsp_ch.ready);
   assign match    = chk_pend_ff && chk_vld_ff && (rd_data == key_ff);
   assign key_ext  = KEXT'(req_ch.key);

   assign ram_rd_en = (state_ff == S_SCAN) && !issue_done_ff;
   assign ram_wr_en = fin_go && (action_ff == ACT_INSERT) && !hit_ff && free_found_ff;

   ukst_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (CAPACITY)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (free_idx_ff),
      .wr_data (key_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (issue_idx_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      rsp_vld_in    = rsp_vld_ff && !rsp_take;
      rsp_status_in = rsp_status_ff;
      slot_vld_in   = slot_vld_ff;
      cnt_in        = cnt_ff;
      action_in     = action_ff;
      key_in        = key_ff;
      issue_idx_in  = issue_idx_ff;
      issue_done_in = issue_done_ff;
      chk_pend_in   = 1'b0;
      chk_idx_in    = chk_idx_ff;
      chk_vld_in    = chk_vld_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               action_in     = req_ch.action;
               key_in        = key_ext[KEY_WIDTH-1:0];
               issue_idx_in  = '0;
               issue_done_in = 1'b0;
               hit_in        = 1'b0;
               free_found_in = 1'b0;
               // Unused action code: skip the walk.
               if (req_ch.action == ACT_INSERT || req_ch.action == ACT_LOOKUP ||
                   req_ch.action == ACT_DELETE) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_SCAN: begin
            // Issue side: read one slot, note the lowest free slot.
            if (!issue_done_ff) begin
               chk_pend_in   = 1'b1;
               chk_idx_in    = issue_idx_ff;
               chk_vld_in    = slot_vld_ff[issue_idx_ff];
               issue_done_in = (issue_idx_ff == LAST_IDX);
               issue_idx_in  = issue_idx_ff + 1'b1;
               if (!slot_vld_ff[issue_idx_ff] && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = issue_idx_ff;
               end
            end
            // Check side: compare the slot read last cycle.
            if (match) begin
               hit_in     = 1'b1;
               hit_idx_in = chk_idx_ff;
               state_in   = S_FINISH;
            end else if (chk_pend_ff && chk_idx_ff == LAST_IDX) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (fin_go) begin
               rsp_status_in = ST_DONE;
               case (action_ff)
                  ACT_INSERT: begin
                     if (hit_ff) begin
                        rsp_status_in = ST_PRESENT;
                     end else if (free_found_ff) begin
                        slot_vld_in[free_idx_ff] = 1'b1;
                        cnt_in = cnt_ff + 1'b1;
                     end else begin
                        rsp_status_in = ST_FULL;
                     end
                  end
                  ACT_LOOKUP: begin
                     if (!hit_ff) begin
                        rsp_status_in = ST_NOT_FOUND;
                     end
                  end
                  ACT_DELETE: begin
                     if (hit_ff) begin
                        slot_vld_in[hit_idx_ff] = 1'b0;
                        cnt_in = cnt_ff - 1'b1;
                     end else begin
                        rsp_status_in = ST_NOT_FOUND;
                     end
                  end
                  default: begin
                     rsp_status_in = ST_DONE;
                  end
               endcase
               rsp_vld_in = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Count after the update, cut or widened to the response field.
   always_comb begin
      cnt_ext      = CWX'(cnt_in);
      rsp_count_in = fin_go ? cnt_ext[COUNT_W-1:0] : rsp_count_ff;
   end

   // State machine and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Table control state and walk control.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_vld_ff <= '{default: 1'b0};
         cnt_ff      <= '0;
         chk_pend_ff <= 1'b0;
      end else begin
         slot_vld_ff <= slot_vld_in;
         cnt_ff      <= cnt_in;
         chk_pend_ff <= chk_pend_in;
      end
   end

   // Walk payload.
   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      key_ff        <= key_in;
      issue_idx_ff  <= issue_idx_in;
      issue_done_ff <= issue_done_in;
      chk_idx_ff    <= chk_idx_in;
      chk_vld_ff    <= chk_vld_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
   end

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_vld_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.entry_count = rsp_count_ff;

endmodule

`default_nettype wire

// File: sv/ukst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ukst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: sv/ukst_chk.sv
// Port-level checker for the unique key set table, with its bind statement.
// Depends on ukst_pkg and on the top level unique_key_set_table.
`default_nettype none

module ukst_chk #(
   parameter int CAPACITY = 64
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [ukst_pkg::STATUS_W-1:0] rsp_status,
   input wire logic [ukst_pkg::COUNT_W-1:0]  rsp_entry_count
);

   import ukst_pkg::*;

   localparam logic [COUNT_W-1:0] CAP_CNT = COUNT_W'(CAPACITY);

   // One request in flight: ready drops after an accepted transaction.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in flight");

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_entry_count)))
      else $error("stalled response changed");

   // A full status is reported only with a full table.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> (rsp_entry_count == CAP_CNT))
      else $error("table full reported below capacity");

   // The count never exceeds the capacity; the check is skipped above 127.
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CAPACITY > 127 || rsp_entry_count <= CAP_CNT))
      else $error("entry count above capacity");

endmodule

bind unique_key_set_table ukst_chk #(
   .CAPACITY (CAPACITY)
) u_ukst_chk (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_status      (rsp_ch.status),
   .rsp_entry_count (rsp_ch.entry_count)
);

`default_nettype wire
